// ===== hw/rtl/least_loaded_dispatcher_unit_assert.svh =====
// Assertion macros shared by the dispatcher RTL.
`ifndef LEAST_LOADED_DISPATCHER_UNIT_ASSERT_SVH
`define LEAST_LOADED_DISPATCHER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define LLD_ASSERT(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("lld assertion failed");

// Check that a condition implies another in the next cycle.
`define LLD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lld assertion failed");

`else

`define LLD_ASSERT(name, expr)
`define LLD_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== hw/rtl/lld_pkg.sv =====
// Types, codes and constants of the least-loaded dispatcher.
package lld_pkg;

  // Default sizing
  localparam int DefMaxWorkers = 16;
  localparam int DefLoadBits   = 16;

  // Field widths
  localparam int CfgW     = 5;
  localparam int IdxW     = 4;
  localparam int OutLoadW = 16;
  localparam int StatusW  = 2;
  localparam int InDataW  = 8;
  localparam int OutDataW = 24;

  // Command kinds
  typedef enum logic {
    CMD_ASSIGN  = 1'b0,
    CMD_RELEASE = 1'b1
  } lld_cmd_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_SAT_HIGH  = 2'd1,
    ST_AT_ZERO   = 2'd2,
    ST_BAD_INDEX = 2'd3
  } lld_status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_UPDATE
  } lld_state_e;

endpackage

// ===== hw/rtl/least_loaded_dispatcher_unit.sv =====
// Least-loaded dispatcher: per-worker load counts in a RAM with a scanning sequencer.
//
// Usage: commands enter on the s_axis channel (tuser = command, 0 assign / 1 release,
// tdata[3:0] = worker index to release). Each command yields exactly one result word
// on m_axis: tdata[3:0] = worker, tdata[19:4] = load after update, tuser = status.
// The worker count register is written over the cfg channel, which is always ready;
// write it only while no command is in flight.
// Sequencing: an assign reads one load count per cycle from the load RAM (single
// registered read port) to find the minimum over the active workers (at most
// MAX_WORKERS). A release reads its worker's count, then updates it; a release of an
// index outside the active set skips the read. One command is processed at a time;
// the next one is taken once the current result is in the output register.
// Reset: all load counts read as zero (per-entry valid flops, no clearing pass),
// the worker count returns to one, the output register empties.
// Stall: a finished result waits in the output register; the sequencer holds its
// update (no RAM write) until that register is free, then accepts new commands.
`include "least_loaded_dispatcher_unit_assert.svh"

module least_loaded_dispatcher_unit #(
  parameter int MAX_WORKERS = lld_pkg::DefMaxWorkers,
  parameter int LOAD_BITS   = lld_pkg::DefLoadBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write channel: number of active workers
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lld_pkg::CfgW-1:0]    cfg_data_i,
  // Command channel
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [lld_pkg::InDataW-1:0] s_axis_tdata_i,   // [3:0] release_worker, [7:4] zero
  input  logic                        s_axis_tuser_i,   // [0] cmd
  // Result channel
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [lld_pkg::OutDataW-1:0] m_axis_tdata_o,  // [3:0] chosen_worker,
                                                        // [19:4] load_after, [23:20] zero
  output logic [lld_pkg::StatusW-1:0] m_axis_tuser_o    // [1:0] status
);
  import lld_pkg::*;

  localparam int AW   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int NW   = $clog2(MAX_WORKERS + 1);
  localparam int CmpW = (NW > CfgW) ? NW : CfgW;
  localparam logic [LOAD_BITS-1:0] LoadMax = '1;

  // Configuration register
  logic [CfgW-1:0] active_q;

  // Load RAM and per-entry valid flops
  logic [LOAD_BITS-1:0]   load_mem [MAX_WORKERS];
  logic [MAX_WORKERS-1:0] valid_q, valid_d;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [LOAD_BITS-1:0]   rd_data_q;
  logic                   rd_valid_q;
  logic                   mem_we;
  logic [AW-1:0]          wr_addr;
  logic [LOAD_BITS-1:0]   wr_data;

  // Sequencer
  lld_state_e           state_q, state_d;
  logic [AW-1:0]        scan_q, scan_d;
  logic [AW-1:0]        best_idx_q, best_idx_d;
  logic [LOAD_BITS-1:0] best_load_q, best_load_d;
  logic                 cmd_q, cmd_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic                 bad_q, bad_d;

  // Output register
  logic                 out_valid_q, out_valid_d;
  logic [IdxW-1:0]      out_worker_q, out_worker_d;
  logic [OutLoadW-1:0]  out_load_q, out_load_d;
  lld_status_e          out_status_q, out_status_d;

  logic                 in_accept;
  logic                 out_free;
  logic                 out_load;
  logic [CmpW-1:0]      act_w;
  logic [CmpW-1:0]      n_eff;
  logic [CmpW-1:0]      scan_next_w;
  logic [LOAD_BITS-1:0] load_cur;
  logic                 take;
  logic [IdxW-1:0]      res_worker;
  logic [LOAD_BITS-1:0] res_load;
  lld_status_e          res_status;
  logic                 res_write;

  // Effective worker count: zero means one, clamp to the RAM depth
  always_comb begin
    act_w = CmpW'(active_q);
    if (act_w == '0) begin
      n_eff = CmpW'(1);
    end else if (act_w > CmpW'(MAX_WORKERS)) begin
      n_eff = CmpW'(MAX_WORKERS);
    end else begin
      n_eff = act_w;
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Entries never written read as zero
  assign load_cur    = rd_valid_q ? rd_data_q : '0;
  assign take        = (scan_q == '0) || (load_cur < best_load_q);
  assign scan_next_w = CmpW'(scan_q) + CmpW'(1);

  // Result of the pending update
  always_comb begin
    res_worker = idx_q;
    res_load   = '0;
    res_status = ST_OK;
    res_write  = 1'b0;
    if (bad_q) begin
      res_status = ST_BAD_INDEX;
    end else if (cmd_q == CMD_ASSIGN) begin
      res_worker = IdxW'(best_idx_q);
      if (best_load_q == LoadMax) begin
        res_load   = LoadMax;
        res_status = ST_SAT_HIGH;
      end else begin
        res_load  = best_load_q + LOAD_BITS'(1);
        res_write = 1'b1;
      end
    end else if (best_load_q == '0) begin
      res_status = ST_AT_ZERO;
    end else begin
      res_load  = best_load_q - LOAD_BITS'(1);
      res_write = 1'b1;
    end
  end

  // Next state and datapath control
  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    best_idx_d   = best_idx_q;
    best_load_d  = best_load_q;
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    bad_d        = bad_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    mem_we       = 1'b0;
    wr_addr      = best_idx_q;
    wr_data      = res_load;
    out_load     = 1'b0;
    valid_d      = valid_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cmd_d = s_axis_tuser_i;
          idx_d = s_axis_tdata_i[IdxW-1:0];
          bad_d = 1'b0;
          if (s_axis_tuser_i == CMD_ASSIGN) begin
            // Start the scan at worker zero
            rd_en   = 1'b1;
            rd_addr = '0;
            scan_d  = '0;
            state_d = S_SCAN;
          end else if (CmpW'(s_axis_tdata_i[IdxW-1:0]) >= n_eff) begin
            bad_d   = 1'b1;
            state_d = S_UPDATE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = AW'(s_axis_tdata_i[IdxW-1:0]);
            state_d = S_FETCH;
          end
        end
      end
      S_SCAN: begin
        // Compare the arriving count, fetch the next one
        if (take) begin
          best_load_d = load_cur;
          best_idx_d  = scan_q;
        end
        if (scan_next_w >= n_eff) begin
          state_d = S_UPDATE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = scan_q + AW'(1);
          scan_d  = scan_q + AW'(1);
        end
      end
      S_FETCH: begin
        best_load_d = load_cur;
        best_idx_d  = AW'(idx_q);
        state_d     = S_UPDATE;
      end
      S_UPDATE: begin
        // Write back and emit only when the output register can take the word
        if (out_free) begin
          out_load = 1'b1;
          mem_we   = res_write;
          if (res_write) begin
            valid_d[best_idx_q] = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register next values
  always_comb begin
    out_worker_d = out_worker_q;
    out_load_d   = out_load_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q;
    if (out_load) begin
      out_worker_d = res_worker;
      out_load_d   = OutLoadW'(res_load);
      out_status_d = res_status;
      out_valid_d  = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      active_q    <= CfgW'(1);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      valid_q     <= valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        active_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    scan_q       <= scan_d;
    best_idx_q   <= best_idx_d;
    best_load_q  <= best_load_d;
    cmd_q        <= cmd_d;
    idx_q        <= idx_d;
    bad_q        <= bad_d;
    out_worker_q <= out_worker_d;
    out_load_q   <= out_load_d;
    out_status_q <= out_status_d;
  end

  // Load RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      load_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q  <= load_mem[rd_addr];
      rd_valid_q <= valid_q[rd_addr];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - IdxW - OutLoadW){1'b0}}, out_load_q, out_worker_q};
  assign m_axis_tuser_o  = out_status_q;

  // Scan never runs past the active workers
  `LLD_ASSERT(a_scan_in_range, (state_q != S_SCAN) || (CmpW'(scan_q) < n_eff))
  // RAM writes only go with a result leaving the sequencer
  `LLD_ASSERT(a_write_with_result, !mem_we || out_load)
  // A written entry is marked valid from then on
  `LLD_ASSERT_NEXT(a_valid_after_write, mem_we, valid_q[$past(wr_addr)])
  // A saturated assign reports the top count
  `LLD_ASSERT(a_sat_reports_max, !(out_load && (res_status == ST_SAT_HIGH)) ||
              (res_load == LoadMax))

endmodule

// ===== sim/tb.sv =====
// Testbench for the least-loaded dispatcher: load-count scoreboard, stream drivers, test plan.
`timescale 1ns / 1ps

module tb;
  import lld_pkg::*;

  localparam int Workers      = DefMaxWorkers;
  localparam int LoadMax      = (1 << DefLoadBits) - 1;
  localparam int TimeoutCycles = 200_000;
  localparam int LongHoldCycles = 300;
  localparam int SettleCycles  = 40;

  // Expected content of one result word
  typedef struct packed {
    logic [IdxW-1:0]     worker;
    logic [OutLoadW-1:0] load;
    lld_status_e         status;
  } dispatch_result_t;

  // Tracks the load of every worker and queues the result each command should yield
  class dispatch_scoreboard;
    logic [DefLoadBits-1:0] loads[Workers];
    logic [CfgW-1:0]        active_cfg;
    dispatch_result_t       pending_results[$];
    int unsigned            mismatches;

    function new();
      foreach (loads[i]) loads[i] = '0;
      active_cfg = CfgW'(1);
      mismatches = 0;
    endfunction

    function void set_active(logic [CfgW-1:0] value);
      active_cfg = value;
    endfunction

    // Clamp the register to the range of workers actually scanned
    function int unsigned worker_span();
      int unsigned n;
      n = active_cfg;
      if (n == 0) n = 1;
      if (n > Workers) n = Workers;
      return n;
    endfunction

    function logic [DefLoadBits-1:0] load_of(int unsigned w);
      return loads[w];
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    // Apply one accepted command and queue its result
    function void note_command(lld_cmd_e cmd, logic [IdxW-1:0] idx);
      dispatch_result_t r;
      int unsigned n;
      int unsigned best;
      n = worker_span();
      if (cmd == CMD_ASSIGN) begin
        best = 0;
        for (int unsigned i = 1; i < n; i++) begin
          if (loads[i] < loads[best]) best = i;
        end
        r.worker = IdxW'(best);
        if (loads[best] == DefLoadBits'(LoadMax)) begin
          r.status = ST_SAT_HIGH;
        end else begin
          loads[best] = loads[best] + 1'b1;
          r.status = ST_OK;
        end
        r.load = OutLoadW'(loads[best]);
      end else begin
        r.worker = idx;
        if (idx >= n) begin
          r.load   = '0;
          r.status = ST_BAD_INDEX;
        end else if (loads[idx] == '0) begin
          r.load   = '0;
          r.status = ST_AT_ZERO;
        end else begin
          loads[idx] = loads[idx] - 1'b1;
          r.load     = OutLoadW'(loads[idx]);
          r.status   = ST_OK;
        end
      end
      pending_results.push_back(r);
    endfunction

    // Compare one result word with the oldest expectation
    function void check_result(logic [OutDataW-1:0] data, logic [StatusW-1:0] user);
      dispatch_result_t exp_r;
      logic [IdxW-1:0]     got_worker;
      logic [OutLoadW-1:0] got_load;
      got_worker = data[IdxW-1:0];
      got_load   = data[IdxW +: OutLoadW];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual worker %0d load %0d status %0d",
                 $time, got_worker, got_load, user);
        mismatches++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got_worker !== exp_r.worker) begin
        $display("%0t: worker mismatch: expected %0d, actual %0d",
                 $time, exp_r.worker, got_worker);
        mismatches++;
      end
      if (got_load !== exp_r.load) begin
        $display("%0t: load mismatch: expected %0d, actual %0d", $time, exp_r.load, got_load);
        mismatches++;
      end
      if (user !== exp_r.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, exp_r.status, user);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgW-1:0]      cfg_data_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [InDataW-1:0]   s_axis_tdata_i;   // [3:0] release_worker, [7:4] zero
  logic                 s_axis_tuser_i;   // [0] cmd
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [OutDataW-1:0]  m_axis_tdata_o;   // [3:0] chosen_worker, [19:4] load_after, [23:20] zero
  logic [StatusW-1:0]   m_axis_tuser_o;   // [1:0] status

  dispatch_scoreboard load_board;
  int unsigned        send_gap_pct;
  int unsigned        recv_stall_pct;
  bit                 long_hold_req;
  int unsigned        hold_left;
  int unsigned        cycle_count;

  least_loaded_dispatcher_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Count cycles for the run limit
  initial cycle_count = 0;
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // End the run if it hangs
  initial begin
    wait (cycle_count >= TimeoutCycles);
    $display("simulation failed");
    $finish;
  end

  // Drive the result ready, with random stalls and an occasional long hold-off
  initial begin
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LongHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check every accepted result word
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      load_board.check_result(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  // Offer one command word, idling first at the current gap rate
  task automatic send_command(input lld_cmd_e cmd, input logic [IdxW-1:0] idx);
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(InDataW-IdxW){1'b0}}, idx};
    s_axis_tuser_i  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    load_board.note_command(cmd, idx);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  // Hold until every result is back and the sequencer has settled
  task automatic drain();
    stop_sending();
    while (load_board.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_active(input logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    load_board.set_active(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned phase);
    case (phase % 4)
      0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_gap_pct = 55; recv_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  recv_stall_pct = 55; end
      default: begin send_gap_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  // Mostly in-range releases mixed with assigns; some releases hit any index
  task automatic send_random(input int unsigned count);
    logic [IdxW-1:0] idx;
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(99) < 55) begin
        send_command(CMD_ASSIGN, IdxW'($urandom_range(15)));
      end else begin
        if ($urandom_range(99) < 80) idx = IdxW'($urandom_range(load_board.worker_span() - 1));
        else idx = IdxW'($urandom_range(15));
        send_command(CMD_RELEASE, idx);
      end
    end
  endtask

  initial begin
    logic [CfgW-1:0] phase_active[8];
    load_board      = new();
    send_gap_pct    = 0;
    recv_stall_pct  = 0;
    long_hold_req   = 1'b0;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = CMD_ASSIGN;
    m_axis_tready_i = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: one worker after reset, release at zero and out of range
    send_command(CMD_RELEASE, 4'd0);
    send_command(CMD_RELEASE, 4'd15);
    send_command(CMD_ASSIGN, 4'd0);
    send_command(CMD_RELEASE, 4'd0);
    send_command(CMD_ASSIGN, 4'd9);
    drain();

    // Zero workers behaves as one
    write_active(5'd0);
    send_command(CMD_ASSIGN, 4'd0);
    send_command(CMD_RELEASE, 4'd1);
    send_command(CMD_ASSIGN, 4'd0);
    drain();

    // Full set: ties go to the lowest index, top index is valid
    write_active(5'd16);
    repeat (4) send_command(CMD_ASSIGN, 4'd0);
    send_command(CMD_RELEASE, 4'd15);
    send_command(CMD_RELEASE, 4'd2);
    send_command(CMD_ASSIGN, 4'd15);
    send_command(CMD_RELEASE, 4'd0);
    drain();

    // Partial set: first index past the set is rejected
    write_active(5'd5);
    send_command(CMD_RELEASE, 4'd5);
    send_command(CMD_RELEASE, 4'd4);
    send_command(CMD_ASSIGN, 4'd0);
    send_command(CMD_RELEASE, 4'd4);
    drain();

    // Random phases over several worker counts, extremes included
    phase_active[0] = 5'd16;
    phase_active[1] = 5'd3;
    phase_active[2] = 5'd0;
    phase_active[3] = 5'd16;
    phase_active[4] = CfgW'($urandom_range(16));
    phase_active[5] = 5'd1;
    phase_active[6] = 5'd8;
    phase_active[7] = 5'd16;
    for (int unsigned p = 0; p < 8; p++) begin
      write_active(phase_active[p]);
      set_idling(p);
      if (p == 1) long_hold_req = 1'b1;
      send_random(63);
      drain();
    end

    if (load_board.mismatches == 0 && load_board.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
